// ===== rtl/core/max_plus_walk_power_core_macros.svh =====
// Assertion macros shared by the max-plus walk power core.
`ifndef MAX_PLUS_WALK_POWER_CORE_MACROS_SVH
`define MAX_PLUS_WALK_POWER_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MPWP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpwp assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define MPWP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpwp assertion failed");

`endif

// ===== rtl/core/mpwp_pkg.sv =====
// Types and constants of the max-plus walk power core.
package mpwp_pkg;

  localparam int DefMaxNodes = 16;

  localparam logic [1:0] RegNodeCount = 2'd0;
  localparam logic [1:0] RegStartNode = 2'd1;
  localparam logic [1:0] RegStepCount = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_GAIN  = 2'd1,
    CMD_EDGE  = 2'd2,
    CMD_RUN   = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_EDGE,
    S_INIT_RD,
    S_INIT_WR,
    S_STEP,
    S_SHIFT,
    S_MUL_RD,
    S_MUL_ADD,
    S_MUL_CMP,
    S_MUL_WR,
    S_CPY_RD,
    S_CPY_WR,
    S_SCAN_RD,
    S_SCAN_ADD,
    S_SCAN_CMP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic               ok;
    logic signed [63:0] v;
  } cell_t;

  typedef struct packed {
    logic add_en;
    logic cmp_en;
    logic first;
  } mac_ctrl_t;

endpackage

// ===== rtl/core/max_plus_walk_power_core.sv =====
// Top level: longest walk of exact length by max-plus matrix squaring.
// Besides a run, the commands set a gain, add an edge or clear the graph (every adjacency cell).
// A run whose start node is out of range skips the final scan of the start row.
// One request at a time; after reset a clearing pass over the graph holds busy high.
// The one result is shown for one cycle by valid_o; the receiver cannot stall.
module max_plus_walk_power_core
  import mpwp_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [3:0]         first_node_i,
  input  logic [3:0]         second_node_i,
  input  logic signed [31:0] gain_value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_wdata_i,
  output logic               valid_o,
  output logic signed [63:0] best_total_o,
  output logic               no_walk_o
);

  `include "max_plus_walk_power_core_macros.svh"

  localparam int NW    = $clog2(MAX_NODES);
  localparam int AW    = 2 * NW;
  localparam int DEPTH = 1 << AW;

  state_e state_q, state_d;

  logic [4:0]    node_count_q;
  logic [3:0]    start_node_q;
  logic [30:0]   step_count_q;

  logic [NW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, nm1_q, nm1_d, ea_q, ea_d, eb_q, eb_d;
  logic [30:0]   p_q, p_d;
  logic          mode_q, mode_d, nrow_q, nrow_d;

  logic          accept, i_last, j_last, k_last, start_ok, edge_ok, gain_ok;
  logic [NW-1:0] nm1_run, start_idx, gain_ra;
  cmd_e          cmd;

  logic [32:0]   adj_mem [DEPTH];
  cell_t         pw_mem [DEPTH];
  cell_t         rs_mem [DEPTH];
  cell_t         sc_mem [DEPTH];
  logic [31:0]   gain_mem [MAX_NODES];
  logic [MAX_NODES-1:0] gvld_q;

  logic [32:0]   adj_rd, adj_wd;
  cell_t         pwa_rd, pwb_rd, rs_rd, sc_rd, pw_wd, rs_wd, adj_cell;
  logic [31:0]   gain_rd;
  logic          gv_q;
  logic          adj_we, pw_we, rs_we, sc_we, gain_we;
  logic [AW-1:0] adj_wa, rs_ra;

  mac_ctrl_t     mac_ctrl;
  cell_t         mac_x, mac_y, best;

  assign cmd       = cmd_e'(command_i);
  assign accept    = start && !busy;
  assign i_last    = (i_q == nm1_q);
  assign j_last    = (j_q == nm1_q);
  assign k_last    = (k_q == nm1_q);
  assign start_idx = NW'(start_node_q);
  assign gain_ra   = NW'(second_node_i);
  assign start_ok  = (32'(start_node_q) <= 32'(nm1_q));
  assign gain_ok   = (32'(first_node_i) < 32'(MAX_NODES));
  assign edge_ok   = gain_ok && (32'(second_node_i) < 32'(MAX_NODES));

  always_comb begin
    if (32'(node_count_q) > 32'(MAX_NODES)) begin
      nm1_run = NW'(MAX_NODES - 1);
    end else if (node_count_q == 5'd0) begin
      nm1_run = '0;
    end else begin
      nm1_run = NW'(node_count_q - 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 5'd16;
      start_node_q <= 4'd0;
      step_count_q <= 31'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegNodeCount: node_count_q <= cfg_wdata_i[4:0];
        RegStartNode: start_node_q <= cfg_wdata_i[3:0];
        RegStepCount: step_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:      if (&{i_q, j_q}) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_CLEAR: state_d = S_CLR;
            CMD_GAIN:  state_d = S_IDLE;
            CMD_EDGE:  state_d = edge_ok ? S_EDGE : S_IDLE;
            CMD_RUN:   state_d = S_INIT_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_EDGE:     state_d = S_IDLE;
      S_INIT_RD:  state_d = S_INIT_WR;
      S_INIT_WR:  state_d = (i_last && j_last) ? S_STEP : S_INIT_RD;
      S_STEP: begin
        if (p_q == 31'd0) begin
          state_d = start_ok ? S_SCAN_RD : S_OUT;
        end else begin
          state_d = p_q[0] ? S_MUL_RD : S_SHIFT;
        end
      end
      S_SHIFT:    state_d = (p_q[30:1] != 30'd0) ? S_MUL_RD : S_STEP;
      S_MUL_RD:   state_d = S_MUL_ADD;
      S_MUL_ADD:  state_d = S_MUL_CMP;
      S_MUL_CMP:  state_d = k_last ? S_MUL_WR : S_MUL_RD;
      S_MUL_WR:   state_d = (i_last && j_last) ? S_CPY_RD : S_MUL_RD;
      S_CPY_RD:   state_d = S_CPY_WR;
      S_CPY_WR: begin
        if (i_last && j_last) begin
          state_d = mode_q ? S_STEP : S_SHIFT;
        end else begin
          state_d = S_CPY_RD;
        end
      end
      S_SCAN_RD:  state_d = S_SCAN_ADD;
      S_SCAN_ADD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: state_d = j_last ? S_OUT : S_SCAN_RD;
      S_OUT:      state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    p_d    = p_q;
    nm1_d  = nm1_q;
    mode_d = mode_q;
    nrow_d = nrow_q;
    ea_d   = ea_q;
    eb_d   = eb_q;
    unique case (state_q)
      S_CLR: {i_d, j_d} = {i_q, j_q} + AW'(1);
      S_IDLE: begin
        if (accept) begin
          i_d  = '0;
          j_d  = '0;
          k_d  = '0;
          ea_d = NW'(first_node_i);
          eb_d = NW'(second_node_i);
          if (cmd == CMD_RUN) begin
            nm1_d = nm1_run;
            p_d   = step_count_q;
          end
        end
      end
      S_STEP: begin
        i_d    = '0;
        j_d    = '0;
        k_d    = '0;
        mode_d = 1'b0;
        nrow_d = !start_ok;
      end
      S_SHIFT: begin
        p_d    = p_q >> 1;
        mode_d = 1'b1;
        i_d    = '0;
        j_d    = '0;
        k_d    = '0;
      end
      S_MUL_CMP: k_d = k_last ? '0 : k_q + NW'(1);
      S_INIT_WR, S_MUL_WR, S_CPY_WR: begin
        if (j_last) begin
          j_d = '0;
          i_d = i_last ? '0 : i_q + NW'(1);
        end else begin
          j_d = j_q + NW'(1);
        end
      end
      S_SCAN_CMP: j_d = j_q + NW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      p_q     <= '0;
      nm1_q   <= '0;
      mode_q  <= 1'b0;
      nrow_q  <= 1'b0;
      ea_q    <= '0;
      eb_q    <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      p_q     <= p_d;
      nm1_q   <= nm1_d;
      mode_q  <= mode_d;
      nrow_q  <= nrow_d;
      ea_q    <= ea_d;
      eb_q    <= eb_d;
    end
  end

  assign adj_cell = '{ok: adj_rd[32], v: {{32{adj_rd[31]}}, adj_rd[31:0]}};

  always_comb begin
    busy     = (state_q != S_IDLE);
    valid_o  = (state_q == S_OUT);
    gain_we  = accept && (cmd == CMD_GAIN) && gain_ok;
    adj_we   = (state_q == S_CLR) || (state_q == S_EDGE);
    adj_wa   = (state_q == S_EDGE) ? {ea_q, eb_q} : {i_q, j_q};
    adj_wd   = (state_q == S_EDGE) ? {1'b1, (gv_q ? gain_rd : 32'd0)} : 33'd0;
    pw_we    = (state_q == S_INIT_WR) || ((state_q == S_CPY_WR) && mode_q);
    pw_wd    = (state_q == S_INIT_WR) ? adj_cell : sc_rd;
    rs_we    = (state_q == S_INIT_WR) || ((state_q == S_CPY_WR) && !mode_q);
    rs_wd    = (state_q == S_INIT_WR) ? '{ok: (i_q == j_q), v: 64'sd0} : sc_rd;
    sc_we    = (state_q == S_MUL_WR);
    rs_ra    = (state_q == S_SCAN_RD) ? {start_idx, j_q} : {i_q, k_q};
    mac_ctrl.add_en = (state_q == S_MUL_ADD) || (state_q == S_SCAN_ADD);
    mac_ctrl.cmp_en = (state_q == S_MUL_CMP) || (state_q == S_SCAN_CMP);
    mac_ctrl.first  = ((state_q == S_MUL_CMP) && (k_q == '0)) ||
                      ((state_q == S_SCAN_CMP) && (j_q == '0));
    if (state_q == S_SCAN_ADD) begin
      mac_x = rs_rd;
      mac_y = '{ok: 1'b1, v: 64'sd0};
    end else begin
      mac_x = mode_q ? pwa_rd : rs_rd;
      mac_y = pwb_rd;
    end
    no_walk_o    = !(best.ok && !nrow_q);
    best_total_o = no_walk_o ? 64'sd0 : best.v;
  end

  always_ff @(posedge clk_i) begin
    if (gain_we) gain_mem[NW'(first_node_i)] <= gain_value_i;
    gain_rd <= gain_mem[gain_ra];
    gv_q    <= gvld_q[gain_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gvld_q <= '0;
    end else if (gain_we) begin
      gvld_q[NW'(first_node_i)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd <= adj_mem[{i_q, j_q}];
  end

  always_ff @(posedge clk_i) begin
    if (pw_we) pw_mem[{i_q, j_q}] <= pw_wd;
    pwa_rd <= pw_mem[{i_q, k_q}];
    pwb_rd <= pw_mem[{k_q, j_q}];
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[{i_q, j_q}] <= rs_wd;
    rs_rd <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) sc_mem[{i_q, j_q}] <= best;
    sc_rd <= sc_mem[{i_q, j_q}];
  end

  mpwp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .x_i    (mac_x),
    .y_i    (mac_y),
    .best_o (best)
  );

  `MPWP_ASSERT_NXT(a_single_strobe, valid_o, !valid_o)
  `MPWP_ASSERT_NXT(a_run_goes_busy, accept && (command_i == CMD_RUN), busy)
  `MPWP_ASSERT_IMP(a_no_walk_zero, valid_o && no_walk_o, best_total_o == 64'sd0)

endmodule

// ===== rtl/core/mpwp_mac.sv =====
// Shared saturating max-plus add and running-maximum unit.
module mpwp_mac
  import mpwp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mac_ctrl_t ctrl_i,
  input  cell_t     x_i,
  input  cell_t     y_i,
  output cell_t     best_o
);

  cell_t       sum_q, sum_d;
  cell_t       best_q, best_d;
  logic [64:0] wide;

  always_comb begin
    wide     = {x_i.v[63], x_i.v} + {y_i.v[63], y_i.v};
    sum_d.ok = x_i.ok & y_i.ok;
    if (wide[64] != wide[63]) begin
      sum_d.v = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_d.v = wide[63:0];
    end
  end

  always_comb begin
    best_d = best_q;
    if (ctrl_i.cmp_en) begin
      if (sum_q.ok && (ctrl_i.first || !best_q.ok || sum_q.v > best_q.v)) begin
        best_d = sum_q;
      end else if (ctrl_i.first) begin
        best_d.ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      best_q <= '0;
    end else begin
      if (ctrl_i.add_en) sum_q <= sum_d;
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule
